FILE: sv/bgvt_pkg.sv
`default_nettype none
package bgvt_pkg;

	localparam int MAX_TILES     = 64;
	localparam int GRID_COLUMNS  = 200;
	localparam int ROWS_PER_BAND = 5;
	localparam int BAND_STRIDE   = GRID_COLUMNS * ROWS_PER_BAND;

	localparam int DIV_W  = 33;
	localparam int REM_W  = 16;
	localparam int CNT_W  = $clog2(DIV_W + 1);
	localparam int RMOD_W = $clog2(ROWS_PER_BAND + 1);
	localparam int COL_W  = $clog2(GRID_COLUMNS + 1);
	localparam int NUM_W  = $clog2(MAX_TILES + 1);
	localparam int POS_W  = 19;
	localparam int IDX_W  = 40;
	localparam int OUT_DATA_W = 112;

	localparam logic [DIV_W-1:0]  LAST_COLUMN   = DIV_W'(GRID_COLUMNS - 1);
	localparam logic [RMOD_W-1:0] RMOD_LAST     = RMOD_W'(ROWS_PER_BAND - 1);
	localparam logic [RMOD_W-1:0] RMOD_OVER     = RMOD_W'(ROWS_PER_BAND);
	localparam logic [IDX_W-1:0]  ROW_WRAP_STEP = IDX_W'(BAND_STRIDE - (ROWS_PER_BAND - 1));
	localparam logic [NUM_W-1:0]  TILE_LIMIT    = NUM_W'(MAX_TILES);

	localparam logic [1:0] REG_TILE_SIZE   = 2'd0;
	localparam logic [1:0] REG_VIEW_WIDTH  = 2'd1;
	localparam logic [1:0] REG_VIEW_HEIGHT = 2'd2;

	typedef struct packed {
		logic             start;
		logic [DIV_W-1:0] dividend;
		logic [REM_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DIV_W-1:0] quot;
		logic [REM_W-1:0] rem;
	} div_rsp_t;

	typedef struct packed {
		logic [DIV_W-1:0]  fr;
		logic [DIV_W-1:0]  lr;
		logic [RMOD_W-1:0] rmod;
		logic [IDX_W-1:0]  idx0;
		logic [POS_W-1:0]  iy0;
		logic [POS_W-1:0]  ix0;
		logic [COL_W-1:0]  fc;
		logic [COL_W-1:0]  lc;
		logic              cols_ok;
		logic [12:0]       q0;
		logic [15:0]       r0;
		logic [12:0]       sz;
		logic [11:0]       gap;
		logic [15:0]       w;
		logic [15:0]       h;
	} job_t;

endpackage
`default_nettype wire

FILE: sv/bgvt_div.sv
`default_nettype none
module bgvt_div import bgvt_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire div_req_t req,
	output div_rsp_t      rsp
);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DIV_W-1:0] dvd_q;
	logic [REM_W-1:0] rem_q;
	logic [REM_W-1:0] dvs_q;
	logic [REM_W:0]   trial;
	logic             ge;
	logic [REM_W-1:0] rem_nx;

	always_comb begin
		trial  = {rem_q, dvd_q[DIV_W-1]};
		ge     = trial >= {1'b0, dvs_q};
		rem_nx = ge ? REM_W'(trial - {1'b0, dvs_q}) : trial[REM_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DIV_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			dvs_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DIV_W-2:0], ge};
			rem_q <= rem_nx;
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = dvd_q;
	assign rsp.rem  = rem_q;

endmodule
`default_nettype wire

FILE: sv/bgvt_front.sv
`default_nettype none
module bgvt_front import bgvt_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        req_valid,
	output logic             req_ready,
	input  wire logic [31:0] req_x,
	input  wire logic [31:0] req_y,
	input  wire logic [12:0] tile_size,
	input  wire logic [15:0] view_width,
	input  wire logic [15:0] view_height,
	output logic             job_push,
	output job_t             job,
	input  wire logic        job_full
);

	localparam logic [3:0] F_IDLE = 4'd0;
	localparam logic [3:0] F_FB   = 4'd1;
	localparam logic [3:0] F_LB   = 4'd2;
	localparam logic [3:0] F_MUL  = 4'd3;
	localparam logic [3:0] F_FR   = 4'd4;
	localparam logic [3:0] F_LR   = 4'd5;
	localparam logic [3:0] F_FC   = 4'd6;
	localparam logic [3:0] F_LC   = 4'd7;
	localparam logic [3:0] F_AT   = 4'd8;
	localparam logic [3:0] F_K    = 4'd9;
	localparam logic [3:0] F_IDX  = 4'd10;
	localparam logic [3:0] F_PUSH = 4'd11;

	logic [3:0]        state_q;
	logic              issued_q;
	logic [31:0]       x_q, y_q;
	logic [12:0]       sz_q;
	logic [11:0]       gap_q;
	logic [15:0]       bandh_q;
	logic [15:0]       w_q, h_q;
	logic [DIV_W-1:0]  fb_q, lb_q, fbo_q, lbo_q, fr_q, lr_q, fc_q, lc_q, band0_q;
	logic [12:0]       yoff_q, xoff_q, q0_q;
	logic [15:0]       r0_q;
	logic [RMOD_W-1:0] rmod0_q;
	logic [POS_W-1:0]  iy0_q;
	logic [IDX_W-1:0]  fc5_q, idx0_q;
	logic [COL_W-1:0]  lc8_q;
	logic              cols_ok_q;

	logic [12:0]       sz_c;
	logic [11:0]       gap_c;
	logic [15:0]       bandh_c;
	logic              div_state;
	logic [DIV_W-1:0]  fb5_c, lc_cl_c;
	logic [RMOD_W-1:0] k_c;
	div_req_t          div_req;
	div_rsp_t          div_rsp;

	bgvt_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_comb begin
		sz_c    = (tile_size == 13'd0) ? 13'd1 : tile_size;
		gap_c   = sz_c[12:1];
		bandh_c = 16'(32'(sz_c) * ROWS_PER_BAND) + 16'(gap_c);
		fb5_c   = DIV_W'(fb_q * DIV_W'(ROWS_PER_BAND));
		k_c     = RMOD_W'(fr_q - fb5_c);
		lc_cl_c = (lc_q > LAST_COLUMN) ? LAST_COLUMN : lc_q;
		div_state = (state_q == F_FB) || (state_q == F_LB) || (state_q == F_FR) ||
			(state_q == F_LR) || (state_q == F_FC) || (state_q == F_LC) ||
			(state_q == F_AT);
		div_req.start    = div_state && !issued_q;
		div_req.dividend = '0;
		div_req.divisor  = 16'(sz_q);
		case (state_q)
			F_FB: begin
				div_req.dividend = DIV_W'(y_q);
				div_req.divisor  = bandh_q;
			end
			F_LB: begin
				div_req.dividend = DIV_W'(y_q) + DIV_W'(h_q);
				div_req.divisor  = bandh_q;
			end
			F_FR: div_req.dividend = DIV_W'(y_q) - fbo_q;
			F_LR: div_req.dividend = DIV_W'(y_q) + DIV_W'(h_q) - lbo_q;
			F_FC: div_req.dividend = DIV_W'(x_q);
			F_LC: div_req.dividend = DIV_W'(x_q) + DIV_W'(w_q);
			F_AT: begin
				div_req.dividend = DIV_W'(sz_q);
				div_req.divisor  = w_q;
			end
			default: div_req.dividend = '0;
		endcase
	end

	assign req_ready = (state_q == F_IDLE);
	assign job_push  = (state_q == F_PUSH) && !job_full;

	always_comb begin
		job.fr      = fr_q;
		job.lr      = lr_q;
		job.rmod    = rmod0_q;
		job.idx0    = idx0_q;
		job.iy0     = iy0_q;
		job.ix0     = POS_W'(0) - POS_W'(xoff_q);
		job.fc      = COL_W'(fc_q);
		job.lc      = lc8_q;
		job.cols_ok = cols_ok_q;
		job.q0      = q0_q;
		job.r0      = r0_q;
		job.sz      = sz_q;
		job.gap     = gap_q;
		job.w       = w_q;
		job.h       = h_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= F_IDLE;
			issued_q <= 1'b0;
		end else begin
			case (state_q)
				F_IDLE: if (req_valid) begin
					state_q  <= F_FB;
					issued_q <= 1'b0;
				end
				F_MUL: state_q <= F_FR;
				F_K:   state_q <= F_IDX;
				F_IDX: state_q <= F_PUSH;
				F_PUSH: if (!job_full) begin
					state_q <= F_IDLE;
				end
				default: begin
					if (!div_state) begin
						state_q <= F_IDLE;
					end else if (!issued_q) begin
						issued_q <= 1'b1;
					end else if (div_rsp.done) begin
						issued_q <= 1'b0;
						state_q  <= (state_q == F_LB) ? F_MUL :
							(state_q == F_AT) ? F_K : state_q + 4'd1;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == F_IDLE && req_valid) begin
			x_q     <= req_x;
			y_q     <= req_y;
			sz_q    <= sz_c;
			gap_q   <= gap_c;
			bandh_q <= bandh_c;
			w_q     <= view_width;
			h_q     <= view_height;
		end
		if (issued_q && div_rsp.done) begin
			case (state_q)
				F_FB: fb_q <= div_rsp.quot;
				F_LB: lb_q <= div_rsp.quot;
				F_FR: begin
					fr_q   <= div_rsp.quot;
					yoff_q <= 13'(div_rsp.rem);
				end
				F_LR: lr_q <= div_rsp.quot;
				F_FC: begin
					fc_q   <= div_rsp.quot;
					xoff_q <= 13'(div_rsp.rem);
				end
				F_LC: lc_q <= div_rsp.quot;
				F_AT: begin
					q0_q <= 13'(div_rsp.quot);
					r0_q <= div_rsp.rem;
				end
				default: ;
			endcase
		end
		if (state_q == F_MUL) begin
			fbo_q <= DIV_W'(45'(gap_q) * 45'(fb_q));
			lbo_q <= DIV_W'(45'(gap_q) * 45'(lb_q));
		end
		if (state_q == F_K) begin
			band0_q   <= fb_q + DIV_W'(k_c == RMOD_OVER);
			rmod0_q   <= (k_c == RMOD_OVER) ? '0 : k_c;
			iy0_q     <= ((k_c == RMOD_OVER) ? POS_W'(gap_q) : POS_W'(0)) - POS_W'(yoff_q);
			fc5_q     <= IDX_W'(fc_q) * IDX_W'(ROWS_PER_BAND);
			lc8_q     <= COL_W'(lc_cl_c);
			cols_ok_q <= fc_q <= lc_cl_c;
		end
		if (state_q == F_IDX) begin
			idx0_q <= IDX_W'(band0_q) * IDX_W'(BAND_STRIDE) + fc5_q + IDX_W'(rmod0_q);
		end
	end

endmodule
`default_nettype wire

FILE: sv/bgvt_fifo.sv
`default_nettype none
module bgvt_fifo import bgvt_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire job_t din,
	output logic      full,
	input  wire logic pop,
	output job_t      dout,
	output logic      empty
);

	job_t       mem_q [2];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;

	assign full  = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign dout  = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= din;
	end

endmodule
`default_nettype wire

FILE: sv/bgvt_back.sv
`default_nettype none
module bgvt_back import bgvt_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  job_valid,
	output logic                       job_pop,
	input  wire job_t                  job,
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic [OUT_DATA_W-1:0]      m_tdata,
	output logic [1:0]                 m_tuser,
	output logic                       m_tlast
);

	localparam logic [1:0] B_IDLE  = 2'd0;
	localparam logic [1:0] B_SCAN  = 2'd1;
	localparam logic [1:0] B_FLUSH = 2'd2;

	logic [1:0]            state_q;
	job_t                  job_q;
	logic [DIV_W-1:0]      r_q;
	logic [RMOD_W-1:0]     rmod_q;
	logic [POS_W-1:0]      iy_q, ix_q;
	logic [IDX_W-1:0]      idx_row_q, idx_q;
	logic                  in_row_q;
	logic [COL_W-1:0]      c_q;
	logic [NUM_W-1:0]      n_q;
	logic [15:0]           ax_q;
	logic [17:0]           ay_q;
	logic                  trunc_q;
	logic                  pend_v_q;
	logic [OUT_DATA_W-1:0] pend_q;
	logic                  out_v_q;
	logic [OUT_DATA_W-1:0] out_data_q;
	logic [1:0]            out_user_q;
	logic                  out_last_q;

	logic                  out_free, iy_ge_h, ix_ge_w, wrap, emit_ok, out_load;
	logic [16:0]           sum_c;
	logic [OUT_DATA_W-1:0] tile_c;

	always_comb begin
		out_free = !out_v_q || m_tready;
		iy_ge_h  = !iy_q[POS_W-1] && (iy_q[POS_W-2:0] >= (POS_W-1)'(job_q.h));
		ix_ge_w  = !ix_q[POS_W-1] && (ix_q[POS_W-2:0] >= (POS_W-1)'(job_q.w));
		sum_c    = {1'b0, ax_q} + {1'b0, job_q.r0};
		wrap     = sum_c >= {1'b0, job_q.w};
		tile_c   = {6'(n_q), ay_q, ax_q, idx_q, iy_q[15:0], ix_q[15:0]};
		emit_ok  = in_row_q && !(c_q > job_q.lc || ix_ge_w) && !ix_q[POS_W-1] &&
			(n_q != TILE_LIMIT);
		out_load = ((state_q == B_SCAN) && emit_ok && pend_v_q && out_free) ||
			((state_q == B_FLUSH) && out_free);
	end

	assign job_pop  = (state_q == B_IDLE) && job_valid;
	assign m_tvalid = out_v_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_user_q;
	assign m_tlast  = out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= B_IDLE;
			in_row_q <= 1'b0;
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (out_load) begin
				out_v_q <= 1'b1;
			end else if (m_tready) begin
				out_v_q <= 1'b0;
			end
			case (state_q)
				B_IDLE: if (job_valid) begin
					in_row_q <= 1'b0;
					pend_v_q <= 1'b0;
					state_q  <= B_SCAN;
				end
				B_SCAN: begin
					if (!in_row_q) begin
						if (r_q > job_q.lr || iy_ge_h) begin
							state_q <= B_FLUSH;
						end else if (!iy_q[POS_W-1] && job_q.cols_ok) begin
							in_row_q <= 1'b1;
						end
					end else if (c_q > job_q.lc || ix_ge_w) begin
						in_row_q <= 1'b0;
					end else if (!ix_q[POS_W-1]) begin
						if (n_q == TILE_LIMIT) begin
							state_q <= B_FLUSH;
						end else if (!pend_v_q || out_free) begin
							pend_v_q <= 1'b1;
						end
					end
				end
				B_FLUSH: if (out_free) begin
					state_q <= B_IDLE;
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			B_IDLE: if (job_valid) begin
				job_q     <= job;
				r_q       <= job.fr;
				rmod_q    <= job.rmod;
				iy_q      <= job.iy0;
				idx_row_q <= job.idx0;
				n_q       <= '0;
				ax_q      <= '0;
				ay_q      <= '0;
				trunc_q   <= 1'b0;
			end
			B_SCAN: begin
				if ((!in_row_q && !(r_q > job_q.lr || iy_ge_h) &&
					(iy_q[POS_W-1] || !job_q.cols_ok)) ||
					(in_row_q && (c_q > job_q.lc || ix_ge_w))) begin
					r_q       <= r_q + 1'b1;
					iy_q      <= iy_q + POS_W'(job_q.sz) +
						((rmod_q == RMOD_LAST) ? POS_W'(job_q.gap) : POS_W'(0));
					rmod_q    <= (rmod_q == RMOD_LAST) ? '0 : rmod_q + 1'b1;
					idx_row_q <= idx_row_q +
						((rmod_q == RMOD_LAST) ? ROW_WRAP_STEP : IDX_W'(1));
				end else if (!in_row_q && !(r_q > job_q.lr || iy_ge_h)) begin
					c_q   <= job_q.fc;
					ix_q  <= job_q.ix0;
					idx_q <= idx_row_q;
				end else if (in_row_q && ix_q[POS_W-1]) begin
					c_q   <= c_q + 1'b1;
					ix_q  <= ix_q + POS_W'(job_q.sz);
					idx_q <= idx_q + IDX_W'(ROWS_PER_BAND);
				end else if (in_row_q) begin
					if (n_q == TILE_LIMIT) begin
						trunc_q <= 1'b1;
					end else if (!pend_v_q || out_free) begin
						if (pend_v_q) begin
							out_data_q <= pend_q;
							out_user_q <= 2'b01;
							out_last_q <= 1'b0;
						end
						pend_q <= tile_c;
						n_q    <= n_q + 1'b1;
						ax_q   <= wrap ? 16'(sum_c - {1'b0, job_q.w}) : sum_c[15:0];
						ay_q   <= ay_q + 18'(job_q.q0) + 18'(wrap);
						c_q    <= c_q + 1'b1;
						ix_q   <= ix_q + POS_W'(job_q.sz);
						idx_q  <= idx_q + IDX_W'(ROWS_PER_BAND);
					end
				end
			end
			B_FLUSH: if (out_free) begin
				out_data_q <= pend_v_q ? pend_q : '0;
				out_user_q <= pend_v_q ? {trunc_q, 1'b1} : 2'b00;
				out_last_q <= 1'b1;
			end
			default: ;
		endcase
	end

endmodule
`default_nettype wire

FILE: sv/banded_grid_viewport_tiles_top.sv
// Setup runs seven 33-step divisions on one shared divider, then the scan visits one
// grid position per cycle while the output is not stalled and sends one tile per
// visible position, up to 64. Setup and scan overlap through a two-entry job queue, so
// the next request can be set up while the last one is scanned.
// Reset: asynchronous, active low; registers return to tile size 64 and a 256 x 256 view,
// and the job queue and result register empty.
`default_nettype none
module banded_grid_viewport_tiles_top import bgvt_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [63:0]           s_tdata,   // view_x, view_y
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic [OUT_DATA_W-1:0]      m_tdata,   // screen_x, screen_y, image_index,
	                                              // atlas_x, atlas_y, tile_number
	output logic [1:0]                 m_tuser,   // tile_valid, truncated
	output logic                       m_tlast,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [1:0]            cfg_index,
	input  wire logic [15:0]           cfg_data
);

	logic [12:0] tile_size_q;
	logic [15:0] view_width_q, view_height_q;
	logic        job_push, job_full, job_empty, job_pop;
	job_t        job_in, job_out;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tile_size_q   <= 13'd64;
			view_width_q  <= 16'd256;
			view_height_q <= 16'd256;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_TILE_SIZE:   tile_size_q   <= cfg_data[12:0];
				REG_VIEW_WIDTH:  view_width_q  <= cfg_data;
				REG_VIEW_HEIGHT: view_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	bgvt_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (s_tvalid),
		.req_ready   (s_tready),
		.req_x       (s_tdata[31:0]),
		.req_y       (s_tdata[63:32]),
		.tile_size   (tile_size_q),
		.view_width  (view_width_q),
		.view_height (view_height_q),
		.job_push    (job_push),
		.job         (job_in),
		.job_full    (job_full)
	);

	bgvt_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (job_push),
		.din    (job_in),
		.full   (job_full),
		.pop    (job_pop),
		.dout   (job_out),
		.empty  (job_empty)
	);

	bgvt_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (!job_empty),
		.job_pop   (job_pop),
		.job       (job_out),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

endmodule
`default_nettype wire

FILE: sv/bgvt_checker.sv
`default_nettype none
module bgvt_checker import bgvt_pkg::*; (
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  s_tvalid,
	input wire logic                  s_tready,
	input wire logic                  m_tvalid,
	input wire logic                  m_tready,
	input wire logic [OUT_DATA_W-1:0] m_tdata,
	input wire logic [1:0]            m_tuser,
	input wire logic                  m_tlast
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("result beat changed while stalled");

	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tlast && m_tdata == '0 && !m_tuser[1])
		else $error("empty view beat is malformed");

	a_trunc: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> m_tlast)
		else $error("truncated flag away from the last beat");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request taken while setup is busy");

endmodule

bind banded_grid_viewport_tiles_top bgvt_checker u_chk (.*);
`default_nettype wire
